// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the continuity monitor RTL.
// Every check is clocked on the rising edge and is disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define CCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("continuity monitor assertion failed");

// Same-cycle implication.
`define CCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `CCM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define CCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    `CCM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ----- rtl/ccm_pkg.sv -----
// Shared types and codes for the consumer continuity monitor.
// No dependencies; used by ccm_tracker and consumer_continuity_monitor_core.
`timescale 1ns / 1ps

package ccm_pkg;

    localparam int TIME_W = 64;

    typedef enum logic [2:0] {
        ST_NORMAL          = 3'd0,
        ST_RAW_CATCHUP     = 3'd1,
        ST_DERIVED_CATCHUP = 3'd2,
        ST_RAW_ONLY_STALE  = 3'd3,
        ST_FATAL           = 3'd4
    } ccm_state_t;

    localparam logic [1:0] OUTBOX_ABSENT    = 2'd0;
    localparam logic [1:0] OUTBOX_UNHEALTHY = 2'd1;

    // Aging flags of one derived consumer, evaluated against its post-update state.
    typedef struct packed {
        logic progress_aged;
        logic bad_aged;
    } ccm_track_t;

endpackage

// ----- rtl/ccm_tracker.sv -----
// Progress and health tracker for one derived consumer (cursor, progress time,
// unhealthy-since time). Depends on ccm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccm_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            upd,
    input  logic [ccm_pkg::TIME_W-1:0]      now_time,
    input  logic [ccm_pkg::TIME_W-1:0]      pos,
    input  logic                            healthy,
    input  logic [ccm_pkg::TIME_W-1:0]      stale_after,
    output ccm_pkg::ccm_track_t             flags
);
    import ccm_pkg::*;

    logic [TIME_W-1:0] prev_pos_reg;
    logic [TIME_W-1:0] progress_time_reg;
    logic [TIME_W-1:0] bad_since_reg;
    logic [TIME_W-1:0] prev_pos_next;
    logic [TIME_W-1:0] progress_time_next;
    logic [TIME_W-1:0] bad_since_next;

    logic              advanced;
    logic              prog_rearm;
    logic              bad_arm;
    logic              zero_window;
    logic [TIME_W:0]   prog_diff;
    logic [TIME_W:0]   bad_diff;
    logic              prog_aged_old;
    logic              bad_aged_old;

    assign advanced   = pos > prev_pos_reg;
    assign prog_rearm = advanced || (progress_time_reg == '0);
    assign bad_arm    = !healthy && (bad_since_reg == '0);

    always_comb
    begin
        prev_pos_next      = advanced ? pos : prev_pos_reg;
        progress_time_next = prog_rearm ? now_time : progress_time_reg;
        if (healthy)
        begin
            bad_since_next = '0;
        end
        else
        begin
            bad_since_next = bad_arm ? now_time : bad_since_reg;
        end
    end

    // Age against the old reference; when the reference is rewritten to now,
    // the elapsed time is zero and only a zero window counts as aged.
    assign zero_window   = (stale_after == '0);
    assign prog_diff     = {1'b0, now_time} - {1'b0, progress_time_reg};
    assign bad_diff      = {1'b0, now_time} - {1'b0, bad_since_reg};
    assign prog_aged_old = !prog_diff[TIME_W] && (prog_diff[TIME_W-1:0] >= stale_after);
    assign bad_aged_old  = !bad_diff[TIME_W] && (bad_diff[TIME_W-1:0] >= stale_after);

    assign flags.progress_aged = prog_rearm ? zero_window : prog_aged_old;
    assign flags.bad_aged      = bad_arm ? zero_window : bad_aged_old;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg      <= '0;
            progress_time_reg <= '0;
            bad_since_reg     <= '0;
        end
        else if (upd)
        begin
            prev_pos_reg      <= prev_pos_next;
            progress_time_reg <= progress_time_next;
            bad_since_reg     <= bad_since_next;
        end
    end

    `CCM_ASSERT_NXT(a_hold_without_upd, clk, rst_n, !upd,
        $stable(prev_pos_reg) && $stable(progress_time_reg) && $stable(bad_since_reg))
    `CCM_ASSERT_NXT(a_cursor_monotonic, clk, rst_n, upd, prev_pos_reg >= $past(prev_pos_reg))
    `CCM_ASSERT_NXT(a_healthy_clears_bad, clk, rst_n, upd && healthy, bad_since_reg == '0)

endmodule

// ----- rtl/consumer_continuity_monitor_core.sv -----
// An accepted sample is held in the input stage; its result is then held in the result register.
// Throughput: one sample per cycle; in_ready drops only when both the input
// stage and the result register hold transactions and out_ready is low.
// Reset (rst_n, async, active low): all trackers, stale_after and valid flags cleared.
// Top level of the consumer continuity monitor; uses ccm_pkg, ccm_tracker, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module consumer_continuity_monitor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ccm_pkg::TIME_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ccm_pkg::TIME_W-1:0]      now_time,
    input  logic [1:0]                      outbox_status,
    input  logic [ccm_pkg::TIME_W-1:0]      raw_position,
    input  logic [ccm_pkg::TIME_W-1:0]      event_position,
    input  logic [ccm_pkg::TIME_W-1:0]      kline_position,
    input  logic [ccm_pkg::TIME_W-1:0]      barrier_position,
    input  logic                            raw_active,
    input  logic                            event_active,
    input  logic                            kline_active,
    input  logic                            raw_healthy,
    input  logic                            event_healthy,
    input  logic                            kline_healthy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      continuity_state,
    output logic                            event_authoritative,
    output logic                            kline_authoritative
);
    import ccm_pkg::*;

    logic [TIME_W-1:0] stale_after_reg;

    // input stage
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic [1:0]        s1_status_reg;
    logic [TIME_W-1:0] s1_raw_pos_reg;
    logic [TIME_W-1:0] s1_ev_pos_reg;
    logic [TIME_W-1:0] s1_kl_pos_reg;
    logic [TIME_W-1:0] s1_barrier_reg;
    logic              s1_raw_en_reg;
    logic              s1_ev_en_reg;
    logic              s1_kl_en_reg;
    logic              s1_raw_ok_reg;
    logic              s1_ev_ok_reg;
    logic              s1_kl_ok_reg;

    // result register
    logic              out_valid_reg;
    ccm_state_t        state_reg;
    logic              ev_auth_reg;
    logic              kl_auth_reg;
    ccm_state_t        state_next;
    logic              ev_auth_next;
    logic              kl_auth_next;

    logic              advance;
    logic              commit;
    logic              trk_upd;
    ccm_track_t        ev_trk;
    ccm_track_t        kl_trk;

    logic              barrier_set;
    logic              raw_at;
    logic              ev_at;
    logic              kl_at;
    logic              derived_ok;
    logic              stale;

    assign advance  = !out_valid_reg || out_ready;
    assign commit   = advance && s1_valid_reg;
    assign in_ready = !s1_valid_reg || advance;
    assign trk_upd  = commit && (s1_status_reg != OUTBOX_ABSENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_after_reg <= '0;
        end
        else if (cfg_we)
        begin
            stale_after_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_now_reg     <= now_time;
            s1_status_reg  <= outbox_status;
            s1_raw_pos_reg <= raw_position;
            s1_ev_pos_reg  <= event_position;
            s1_kl_pos_reg  <= kline_position;
            s1_barrier_reg <= barrier_position;
            s1_raw_en_reg  <= raw_active;
            s1_ev_en_reg   <= event_active;
            s1_kl_en_reg   <= kline_active;
            s1_raw_ok_reg  <= raw_healthy;
            s1_ev_ok_reg   <= event_healthy;
            s1_kl_ok_reg   <= kline_healthy;
        end
    end

    ccm_tracker u_event_trk (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (trk_upd),
        .now_time    (s1_now_reg),
        .pos         (s1_ev_pos_reg),
        .healthy     (s1_ev_ok_reg),
        .stale_after (stale_after_reg),
        .flags       (ev_trk)
    );

    ccm_tracker u_kline_trk (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (trk_upd),
        .now_time    (s1_now_reg),
        .pos         (s1_kl_pos_reg),
        .healthy     (s1_kl_ok_reg),
        .stale_after (stale_after_reg),
        .flags       (kl_trk)
    );

    assign barrier_set = (s1_barrier_reg != '0);
    assign raw_at = !s1_raw_en_reg || (barrier_set && (s1_raw_pos_reg >= s1_barrier_reg));
    assign ev_at  = !s1_ev_en_reg || (barrier_set && (s1_ev_pos_reg >= s1_barrier_reg));
    assign kl_at  = !s1_kl_en_reg || (barrier_set && (s1_kl_pos_reg >= s1_barrier_reg));
    assign derived_ok = (!s1_ev_en_reg || s1_ev_ok_reg) && (!s1_kl_en_reg || s1_kl_ok_reg);

    assign stale = (s1_ev_en_reg && !ev_at && ev_trk.progress_aged)
                || (s1_kl_en_reg && !kl_at && kl_trk.progress_aged)
                || (s1_ev_en_reg && !s1_ev_ok_reg && ev_trk.bad_aged)
                || (s1_kl_en_reg && !s1_kl_ok_reg && kl_trk.bad_aged);

    always_comb
    begin
        ev_auth_next = 1'b0;
        kl_auth_next = 1'b0;
        if (s1_status_reg == OUTBOX_ABSENT || s1_status_reg == OUTBOX_UNHEALTHY)
        begin
            state_next = ST_FATAL;
        end
        else
        begin
            ev_auth_next = s1_ev_en_reg && s1_ev_ok_reg && barrier_set && ev_at;
            kl_auth_next = s1_kl_en_reg && s1_kl_ok_reg && barrier_set && kl_at;
            priority if (stale)
            begin
                state_next = ST_RAW_ONLY_STALE;
            end
            else if (!derived_ok || !(ev_at && kl_at))
            begin
                state_next = ST_DERIVED_CATCHUP;
            end
            else if ((s1_raw_en_reg && !s1_raw_ok_reg) || !raw_at)
            begin
                state_next = ST_RAW_CATCHUP;
            end
            else
            begin
                state_next = ST_NORMAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            state_reg   <= state_next;
            ev_auth_reg <= ev_auth_next;
            kl_auth_reg <= kl_auth_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign continuity_state    = state_reg;
    assign event_authoritative = ev_auth_reg;
    assign kline_authoritative = kl_auth_reg;

    `CCM_ASSERT_NXT(a_absent_is_fatal, clk, rst_n,
        commit && (s1_status_reg == OUTBOX_ABSENT),
        out_valid && (continuity_state == ST_FATAL) && !event_authoritative
        && !kline_authoritative)
    `CCM_ASSERT_IMP(a_auth_not_fatal, clk, rst_n,
        out_valid && (event_authoritative || kline_authoritative),
        continuity_state != ST_FATAL)
    `CCM_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready,
        s1_valid_reg && out_valid_reg && !out_ready)

endmodule
